// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ILD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ild assertion failed");

// Expression must never be true outside reset.
`define ILD_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("ild forbidden condition seen");

`endif

// ===== sv/ild_pkg.sv =====
`timescale 1ns / 1ps
package ild_pkg;

  localparam logic [7:0] PFX_OPSZ    = 8'h66;
  localparam logic [7:0] PFX_ADSZ    = 8'h67;
  localparam logic [3:0] PFX_GRP_HI  = 4'hF;
  localparam logic [3:0] REX_HI      = 4'h4;
  localparam logic [7:0] ESC_0F      = 8'h0F;
  localparam logic [7:0] OP_MOV_IMM  = 8'hC7;
  localparam logic [7:0] OP_GRP1_IMM = 8'h81;

  localparam int PCNT_W  = 4;
  localparam int LEN_W   = 5;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pfx;
    logic       rex;
    logic       esc;
    logic       imm_op;
    logic [1:0] mode;
    logic       sib_need;
  } cls_t;

  typedef struct packed {
    logic             ok;
    logic [7:0]       prim;
    logic [7:0]       sec;
    logic [7:0]       rex;
    logic [7:0]       modrm;
    logic [7:0]       sib;
    logic [31:0]      imm;
    logic [LEN_W-1:0] len;
  } res_t;

endpackage

// ===== sv/instruction_length_decoder.sv =====
`timescale 1ns / 1ps
// Instruction length decoder.
// Input channel (in_): one instruction stream byte per request, with
// in_buffer_end marking the last byte available in the buffer.
// Output channel (out_): one descriptor per instruction, or an invalid
// descriptor (decode_ok 0, length 0) when the buffer ends mid-instruction.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
// Throughput: one byte per cycle sustained while out_stall holds no
// descriptor; the byte state machine in the back end advances once per
// cycle. The descriptor reaches out_ after the byte that completes it
// passes through the 4-entry queue and then the output register.
// Reset (rst_n low, synchronous): queue empties, output drops valid and the
// decoder returns to prefix scan.
// While out_stall is high and a descriptor waits, the descriptor and the
// decoder both hold; the queue keeps taking bytes and in_stall rises
// once its 4 entries are occupied.
module instruction_length_decoder #(
  parameter int PREFIX_LIMIT = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_stream_byte,
  input  logic                       in_buffer_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_decode_ok,
  output logic [7:0]                 out_primary_opcode,
  output logic [7:0]                 out_secondary_opcode,
  output logic [7:0]                 out_rex_byte,
  output logic [7:0]                 out_modrm_byte,
  output logic [7:0]                 out_sib_byte,
  output logic [31:0]                out_immediate,
  output logic [ild_pkg::LEN_W-1:0]  out_instr_length
);
  import ild_pkg::*;

  logic q_full, push, pop, q_valid;
  cls_t cls, q_data;
  res_t res;

  assign in_stall = q_full;

  ild_classify u_classify (
    .in_valid       (in_valid),
    .q_full         (q_full),
    .in_stream_byte (in_stream_byte),
    .in_buffer_end  (in_buffer_end),
    .push           (push),
    .cls            (cls)
  );

  ild_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (cls),
    .pop      (pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  ild_decode #(
    .PREFIX_LIMIT (PREFIX_LIMIT)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_decode_ok        = res.ok;
  assign out_primary_opcode   = res.prim;
  assign out_secondary_opcode = res.sec;
  assign out_rex_byte         = res.rex;
  assign out_modrm_byte       = res.modrm;
  assign out_sib_byte         = res.sib;
  assign out_immediate        = res.imm;
  assign out_instr_length     = res.len;

endmodule

// ===== sv/ild_classify.sv =====
`timescale 1ns / 1ps
module ild_classify (
  input  logic             in_valid,
  input  logic             q_full,
  input  logic [7:0]       in_stream_byte,
  input  logic             in_buffer_end,
  output logic             push,
  output ild_pkg::cls_t    cls
);
  import ild_pkg::*;

  assign push = in_valid && !q_full;

  always_comb begin
    cls.data     = in_stream_byte;
    cls.last     = in_buffer_end;
    cls.pfx      = (in_stream_byte == PFX_OPSZ) || (in_stream_byte == PFX_ADSZ) ||
                   (in_stream_byte[7:4] == PFX_GRP_HI);
    cls.rex      = (in_stream_byte[7:4] == REX_HI);
    cls.esc      = (in_stream_byte == ESC_0F);
    cls.imm_op   = (in_stream_byte == OP_MOV_IMM) || (in_stream_byte == OP_GRP1_IMM);
    cls.mode     = in_stream_byte[7:6];
    cls.sib_need = (in_stream_byte[7:6] != 2'b11) && (in_stream_byte[2:0] == 3'd4);
  end

endmodule

// ===== sv/ild_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ild_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ild_pkg::cls_t wr_data,
  input  logic          pop,
  output logic          full,
  output logic          rd_valid,
  output ild_pkg::cls_t rd_data
);
  import ild_pkg::*;

  localparam logic [Q_AW:0] DEPTH_CNT = (Q_AW+1)'(Q_DEPTH);

  cls_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == DEPTH_CNT);
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ILD_NEVER(a_cnt_over, count_r > DEPTH_CNT)
  `ILD_ASSERT(a_ptr_gap, (wr_ptr_r - rd_ptr_r) == count_r[Q_AW-1:0])
  `ILD_ASSERT(a_cnt_up, do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)

endmodule

// ===== sv/ild_decode.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ild_decode #(
  parameter int PREFIX_LIMIT = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ild_pkg::cls_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output ild_pkg::res_t res
);
  import ild_pkg::*;

  localparam logic [PCNT_W-1:0] PFX_LIM = PCNT_W'(PREFIX_LIMIT);

  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_OPCODE = 3'd1;
  localparam logic [2:0] PH_SECOND = 3'd2;
  localparam logic [2:0] PH_MODRM  = 3'd3;
  localparam logic [2:0] PH_SIB    = 3'd4;
  localparam logic [2:0] PH_DISP   = 3'd5;
  localparam logic [2:0] PH_IMM    = 3'd6;

  logic [2:0]        phase_r, phase_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [LEN_W-1:0]  bytes_r, bytes_nxt;
  logic [2:0]        disp_r, disp_nxt;
  logic [2:0]        imm_left_r, imm_left_nxt;
  logic              imm_op_r, imm_op_nxt;
  logic [7:0]        rex_r, rex_nxt;
  logic [7:0]        prim_r, prim_nxt;
  logic [7:0]        sec_r, sec_nxt;
  logic [7:0]        modrm_r, modrm_nxt;
  logic [7:0]        sib_r, sib_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              out_valid_r;
  res_t              res_r;

  logic              done, emit, go_disp, go_imm;
  logic [1:0]        mode_sel;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign emit      = done || q_data.last;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt    = phase_r;
    pcnt_nxt     = pcnt_r;
    bytes_nxt    = bytes_r + 1'b1;
    disp_nxt     = disp_r;
    imm_left_nxt = imm_left_r;
    imm_op_nxt   = imm_op_r;
    rex_nxt      = rex_r;
    prim_nxt     = prim_r;
    sec_nxt      = sec_r;
    modrm_nxt    = modrm_r;
    sib_nxt      = sib_r;
    acc_nxt      = acc_r;
    done         = 1'b0;
    go_disp      = 1'b0;
    go_imm       = 1'b0;
    mode_sel     = modrm_r[7:6];
    case (phase_r)
      PH_PREFIX: begin
        if ((pcnt_r < PFX_LIM) && q_data.pfx) begin
          pcnt_nxt = pcnt_r + 1'b1;
        end else if (q_data.rex) begin
          rex_nxt   = q_data.data;
          phase_nxt = PH_OPCODE;
        end else begin
          prim_nxt   = q_data.data;
          imm_op_nxt = q_data.imm_op;
          phase_nxt  = q_data.esc ? PH_SECOND : PH_MODRM;
        end
      end
      PH_OPCODE: begin
        prim_nxt   = q_data.data;
        imm_op_nxt = q_data.imm_op;
        phase_nxt  = q_data.esc ? PH_SECOND : PH_MODRM;
      end
      PH_SECOND: begin
        sec_nxt   = q_data.data;
        phase_nxt = PH_MODRM;
      end
      PH_MODRM: begin
        modrm_nxt = q_data.data;
        mode_sel  = q_data.mode;
        if (q_data.sib_need) begin
          phase_nxt = PH_SIB;
        end else begin
          go_disp = 1'b1;
        end
      end
      PH_SIB: begin
        sib_nxt = q_data.data;
        go_disp = 1'b1;
      end
      PH_DISP: begin
        disp_nxt = disp_r - 1'b1;
        go_imm   = (disp_nxt == '0);
      end
      PH_IMM: begin
        case (imm_left_r)
          3'd4:    acc_nxt[7:0]   = q_data.data;
          3'd3:    acc_nxt[15:8]  = q_data.data;
          3'd2:    acc_nxt[23:16] = q_data.data;
          3'd1:    acc_nxt[31:24] = q_data.data;
          default: acc_nxt        = acc_r;
        endcase
        imm_left_nxt = imm_left_r - 1'b1;
        done         = (imm_left_nxt == '0);
      end
      default: begin
        phase_nxt = PH_PREFIX;
      end
    endcase
    if (go_disp) begin
      if (mode_sel == 2'b01 || mode_sel == 2'b10) begin
        disp_nxt  = (mode_sel == 2'b01) ? 3'd1 : 3'd4;
        phase_nxt = PH_DISP;
      end else begin
        go_imm = 1'b1;
      end
    end
    if (go_imm) begin
      if (imm_op_nxt) begin
        imm_left_nxt = 3'd4;
        phase_nxt    = PH_IMM;
      end else begin
        done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PREFIX;
      pcnt_r     <= '0;
      bytes_r    <= '0;
      disp_r     <= '0;
      imm_left_r <= '0;
      imm_op_r   <= 1'b0;
      rex_r      <= '0;
      prim_r     <= '0;
      sec_r      <= '0;
      modrm_r    <= '0;
      sib_r      <= '0;
      acc_r      <= '0;
    end else if (pop) begin
      if (emit) begin
        phase_r    <= PH_PREFIX;
        pcnt_r     <= '0;
        bytes_r    <= '0;
        disp_r     <= '0;
        imm_left_r <= '0;
        imm_op_r   <= 1'b0;
        rex_r      <= '0;
        prim_r     <= '0;
        sec_r      <= '0;
        modrm_r    <= '0;
        sib_r      <= '0;
        acc_r      <= '0;
      end else begin
        phase_r    <= phase_nxt;
        pcnt_r     <= pcnt_nxt;
        bytes_r    <= bytes_nxt;
        disp_r     <= disp_nxt;
        imm_left_r <= imm_left_nxt;
        imm_op_r   <= imm_op_nxt;
        rex_r      <= rex_nxt;
        prim_r     <= prim_nxt;
        sec_r      <= sec_nxt;
        modrm_r    <= modrm_nxt;
        sib_r      <= sib_nxt;
        acc_r      <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_r.ok    <= done;
      res_r.prim  <= prim_nxt;
      res_r.sec   <= sec_nxt;
      res_r.rex   <= rex_nxt;
      res_r.modrm <= modrm_nxt;
      res_r.sib   <= sib_nxt;
      res_r.imm   <= done ? acc_nxt : 32'd0;
      res_r.len   <= done ? bytes_nxt : '0;
    end
  end

  `ILD_ASSERT(a_restart, pop && emit |=> phase_r == PH_PREFIX && bytes_r == '0)
  `ILD_NEVER(a_pcnt_lim, pcnt_r > PFX_LIM)
  `ILD_ASSERT(a_no_pop_full, out_valid_r && out_stall |-> !pop)

endmodule
